FILE: hw/rtl/stable_priority_queue_core_macros.svh
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// concurrent checks on the rising clock edge, disabled during reset
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable priority queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable priority queue check failed");

`else

`define SPQ_ASSERT_IMPL(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the stable priority queue cells and top level
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } spq_op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed
    {
        spq_op_t             opcode;
        logic [ID_W-1:0]     entry_id;
        logic [PRIO_W-1:0]   entry_priority;
    } spq_in_t;

    typedef struct packed
    {
        spq_status_t         status;
        logic [ID_W-1:0]     popped_id;
        logic [PRIO_W-1:0]   popped_priority;
        logic [OCC_W-1:0]    occupancy;
    } spq_out_t;

    typedef struct packed
    {
        logic [ID_W-1:0]     entry_id;
        logic [PRIO_W-1:0]   entry_priority;
    } spq_entry_t;

    typedef struct packed
    {
        logic                push_en;
        logic                pop_en;
        spq_entry_t          new_entry;
    } spq_cell_ctrl_t;

endpackage

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted shift register: holds an entry, compares it with the
// incoming entry and shifts towards the tail on push or the head on pop
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic                    clk,
    input  spq_pkg::spq_cell_ctrl_t ctrl,
    input  logic                    occupied,
    input  logic                    left_go,
    input  spq_pkg::spq_entry_t     left_entry,
    input  spq_pkg::spq_entry_t     right_entry,
    output logic                    go,
    output spq_pkg::spq_entry_t     entry
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // entry moves right when the slot is free or holds a strictly larger priority
    assign go = !occupied || (entry_reg.entry_priority > ctrl.new_entry.entry_priority);

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.push_en && go)
        begin
            entry_next = left_go ? left_entry : ctrl.new_entry;
        end
        else if (ctrl.pop_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: hw/rtl/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// bounded priority queue, lowest priority value first, equal values in
// arrival order
// ----------------------------------------------------------------------------
// Each transfer is a push or a pop and gives exactly one result transfer. An
// item is decided in the cycle it is taken: every cell of the sorted shift
// register compares its own priority with the incoming one in parallel, so a
// push or pop settles within the cycle it is taken and the result lands in the output
// register at the edge that accepts the item. The block sustains one item per
// cycle while the output side takes results; a new item
// is taken when the output register is empty or is being emptied in the same
// cycle. The effective capacity is the lesser of the capacity register and
// DEPTH. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module stable_priority_queue_core
#(
    parameter int DEPTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  spq_pkg::spq_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output spq_pkg::spq_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]      cfg_wdata
);
    import spq_pkg::*;

`include "stable_priority_queue_core_macros.svh"

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    spq_out_t          out_data_reg;
    spq_out_t          out_data_next;

    logic              in_xfer;
    logic              is_full;
    logic              store_empty;
    logic [CMP_W-1:0]  fill_ext;
    logic [CMP_W-1:0]  fill_next_ext;
    logic [CMP_W-1:0]  cap_ext;
    spq_cell_ctrl_t    cell_ctrl;
    spq_entry_t        cell_entry [DEPTH];
    logic [DEPTH-1:0]  cell_go;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    assign fill_ext    = CMP_W'(fill_count_reg);
    assign cap_ext     = CMP_W'(capacity_reg);
    assign is_full     = (fill_ext >= cap_ext) || (fill_ext >= CMP_W'(DEPTH));
    assign store_empty = (fill_count_reg == '0);

    assign cell_ctrl.push_en   = in_xfer && (in_data.opcode == OP_PUSH) && !is_full;
    assign cell_ctrl.pop_en    = in_xfer && (in_data.opcode == OP_POP) && !store_empty;
    assign cell_ctrl.new_entry.entry_id       = in_data.entry_id;
    assign cell_ctrl.new_entry.entry_priority = in_data.entry_priority;

    // cell chain, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       left_go;
        spq_entry_t left_entry;
        spq_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_go    = 1'b0;
            assign left_entry = cell_ctrl.new_entry;
        end
        else
        begin : g_body
            assign left_go    = cell_go[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .occupied    (FILL_W'(i) < fill_count_reg),
            .left_go     (left_go),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .go          (cell_go[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cell_ctrl.push_en)
        begin
            fill_count_next = fill_count_reg + 1'b1;
        end
        else if (cell_ctrl.pop_en)
        begin
            fill_count_next = fill_count_reg - 1'b1;
        end
    end

    assign fill_next_ext = CMP_W'(fill_count_next);

    always_comb
    begin
        out_data_next.status          = ST_DONE;
        out_data_next.popped_id       = '0;
        out_data_next.popped_priority = '0;
        out_data_next.occupancy       = fill_next_ext[OCC_W-1:0];
        unique case (in_data.opcode)
            OP_PUSH:
            begin
                if (is_full)
                begin
                    out_data_next.status = ST_FULL;
                end
            end
            OP_POP:
            begin
                if (store_empty)
                begin
                    out_data_next.status = ST_EMPTY;
                end
                else
                begin
                    out_data_next.popped_id       = cell_entry[0].entry_id;
                    out_data_next.popped_priority = cell_entry[0].entry_priority;
                end
            end
            default:
            begin
                out_data_next.status = ST_DONE;
            end
        endcase
    end

    assign out_valid_next = in_xfer || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            capacity_reg   <= CAP_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SPQ_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ext <= CMP_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_refused_push_holds,
                     in_xfer && (in_data.opcode == OP_PUSH) && is_full,
                     $stable(fill_count_reg))
    `SPQ_ASSERT_NEXT(a_pop_shrinks, cell_ctrl.pop_en,
                     fill_count_reg == $past(fill_count_reg) - 1'b1)
    `SPQ_ASSERT_IMPL(a_head_sorted, fill_ext >= CMP_W'(2),
                     cell_entry[0].entry_priority <= cell_entry[1].entry_priority)
    `SPQ_ASSERT_NEXT(a_result_follows, in_xfer, out_valid_reg)

endmodule
